// ===== rtl/ppef_pkg.sv =====
// ----------------------------------------------------------------------------
// ppef_pkg
// shared types, sizes and character codes of the printer pass-through filter
// ----------------------------------------------------------------------------
package ppef_pkg;

    // sequence store sizing
    localparam int SEQ_DEPTH = 16;
    localparam int IDX_W     = $clog2(SEQ_DEPTH);
    localparam int LEN_W     = $clog2(SEQ_DEPTH + 1);

    // control characters
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_XON  = 8'h11;
    localparam logic [7:0] CH_XOFF = 8'h13;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_CSI  = 8'h9B;

    // printable characters used by the sequence parser
    localparam logic [7:0] CH_4      = 8'h34;
    localparam logic [7:0] CH_5      = 8'h35;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_8      = 8'h38;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_HASH   = 8'h23;

    // action that the current input item calls for
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_PASS   = 2'd1;
    localparam logic [1:0] ACT_MARK   = 2'd2;
    localparam logic [1:0] ACT_REPLAY = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic take;      // input item accepted this cycle
        logic load_rep;  // load next replay byte into the output register
    } ppef_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic       out_free;  // output register can take a new item
        logic [1:0] act;       // action of the item on the input
        logic       rep_last;  // replay index points at the final stored byte
    } ppef_stat_t;

endpackage

// ===== rtl/ppef_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppef_ctrl
// controller: runs the input side and steps through sequence replays
// ----------------------------------------------------------------------------
module ppef_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ppef_pkg::ppef_stat_t stat,
    output ppef_pkg::ppef_cmd_t  cmd
);
    import ppef_pkg::*;

    localparam logic ST_RUN    = 1'b0;
    localparam logic ST_REPLAY = 1'b1;

    logic state_reg;
    logic state_next;

    // handshake and commands
    always_comb
    begin
        s_tready     = 1'b0;
        cmd.take     = 1'b0;
        cmd.load_rep = 1'b0;
        state_next   = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                s_tready = stat.out_free;
                cmd.take = s_tvalid & stat.out_free;
                if (cmd.take && stat.act == ACT_REPLAY)
                begin
                    state_next = ST_REPLAY;
                end
            end
            ST_REPLAY:
            begin
                cmd.load_rep = stat.out_free;
                if (stat.out_free && stat.rep_last)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ppef_dp.sv =====
// ----------------------------------------------------------------------------
// ppef_dp
// datapath: byte classifier, sequence store, replay index and output register
// ----------------------------------------------------------------------------
module ppef_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           s_tdata,    // in_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,    // out_byte
    output logic [2:0]           m_tuser,    // has_byte, leave_mode, truncated
    output logic                 m_tlast,
    input  ppef_pkg::ppef_cmd_t  cmd,
    output ppef_pkg::ppef_stat_t stat
);
    import ppef_pkg::*;

    logic [7:0]       store_reg [SEQ_DEPTH];
    logic             in_seq_reg;
    logic             in_seq_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [7:0]       prev_reg;
    logic [7:0]       prev_next;
    logic [IDX_W-1:0] rep_idx_reg;
    logic [IDX_W-1:0] rep_idx_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_has_reg;
    logic             out_leave_reg;
    logic             out_trunc_reg;
    logic             out_last_reg;

    logic [7:0] b;
    logic       is_ctl_drop;
    logic       is_open;
    logic       is_letter;
    logic       is_term;
    logic       room;
    logic       is_match;
    logic       wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [1:0] act;
    logic       out_free;
    logic       rep_last;

    assign b = s_tdata;

    // byte classification
    always_comb
    begin
        is_ctl_drop = (b == CH_XON) || (b == CH_XOFF) || (b == CH_NUL);
        is_open     = (b == CH_ESC) || (b == CH_CSI);
        is_letter   = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
        is_term     = is_letter
                   || (b == CH_AT) || (b == CH_LT) || (b == CH_EQ)
                   || (b == CH_GT) || (b == CH_TILDE)
                   || (prev_reg == CH_HASH)
                   || ((prev_reg == CH_ESC) && ((b == CH_7) || (b == CH_8)));
        room        = len_reg < LEN_W'(SEQ_DEPTH - 1);
        // exactly ESC [ 4 i or ESC [ 5 i once the terminator lands
        is_match    = (len_reg == LEN_W'(3)) && (store_reg[1] == CH_LBRACK)
                   && ((store_reg[2] == CH_4) || (store_reg[2] == CH_5))
                   && (b == CH_I);
    end

    // action of the item on the input
    always_comb
    begin
        if (!in_seq_reg)
        begin
            act = (is_ctl_drop || is_open) ? ACT_NONE : ACT_PASS;
        end
        else if (!is_term)
        begin
            act = ACT_NONE;
        end
        else if (is_match)
        begin
            act = (store_reg[2] == CH_4) ? ACT_MARK : ACT_NONE;
        end
        else
        begin
            act = ACT_REPLAY;
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign rep_last = (LEN_W'(rep_idx_reg) + LEN_W'(1)) == len_reg;

    // status to the controller
    assign stat = {out_free, act, rep_last};

    // sequence state update
    always_comb
    begin
        in_seq_next  = in_seq_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        prev_next    = prev_reg;
        rep_idx_next = rep_idx_reg;
        wr_en        = 1'b0;
        if (cmd.take)
        begin
            rep_idx_next = '0;
            if (!in_seq_reg)
            begin
                if (is_open)
                begin
                    in_seq_next = 1'b1;
                    ovf_next    = 1'b0;
                    if (b == CH_CSI)
                    begin
                        len_next  = LEN_W'(2);
                        prev_next = CH_LBRACK;
                    end
                    else
                    begin
                        len_next  = LEN_W'(1);
                        prev_next = CH_ESC;
                    end
                end
            end
            else if (!is_term)
            begin
                if (room)
                begin
                    wr_en     = 1'b1;
                    len_next  = len_reg + LEN_W'(1);
                    prev_next = b;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                // terminator always has the reserved last slot
                wr_en       = 1'b1;
                len_next    = len_reg + LEN_W'(1);
                prev_next   = b;
                in_seq_next = 1'b0;
            end
        end
        else if (cmd.load_rep)
        begin
            rep_idx_next = rep_idx_reg + IDX_W'(1);
        end
    end

    assign wr_idx = len_reg[IDX_W-1:0];

    // sequence store
    always_ff @(posedge clk)
    begin
        if (cmd.take && !in_seq_reg && is_open)
        begin
            store_reg[0] <= CH_ESC;
            store_reg[1] <= CH_LBRACK;
        end
        else if (wr_en)
        begin
            store_reg[wr_idx] <= b;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seq_reg    <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            prev_reg      <= '0;
            rep_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_seq_reg    <= in_seq_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            prev_reg      <= prev_next;
            rep_idx_reg   <= rep_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if ((cmd.take && (act == ACT_PASS || act == ACT_MARK)) || cmd.load_rep)
        begin
            out_valid_next = 1'b1;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_rep)
        begin
            out_byte_reg  <= store_reg[rep_idx_reg];
            out_has_reg   <= 1'b1;
            out_leave_reg <= 1'b0;
            out_trunc_reg <= ovf_reg;
            out_last_reg  <= rep_last;
        end
        else if (cmd.take && act == ACT_PASS)
        begin
            out_byte_reg  <= b;
            out_has_reg   <= 1'b1;
            out_leave_reg <= 1'b0;
            out_trunc_reg <= 1'b0;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.take && act == ACT_MARK)
        begin
            out_byte_reg  <= '0;
            out_has_reg   <= 1'b0;
            out_leave_reg <= 1'b1;
            out_trunc_reg <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_trunc_reg, out_leave_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/printer_passthrough_escape_filter.sv =====
// ----------------------------------------------------------------------------
// printer_passthrough_escape_filter
// printer controller mode byte filter with escape sequence buffering
// ----------------------------------------------------------------------------
// Ordinary bytes, the sequence bytes being buffered and dropped control bytes
// are each one input item, so the input runs at one item per cycle while no
// replay runs and the output register is free. A terminator that finishes a
// sequence to be replayed holds the input until every stored byte (at most
// the store depth) has been loaded: the single output register is loaded from
// the store one entry per cycle. An ESC[4i gives one mode-exit item (has_byte 0,
// leave_mode 1); ESC[5i gives nothing. Output back-pressure adds its own stalls.
module printer_passthrough_escape_filter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [2:0] m_tuser,   // has_byte, leave_mode, truncated
    output logic       m_tlast    // last
);
    import ppef_pkg::*;

    ppef_cmd_t  cmd;
    ppef_stat_t stat;

    // sequencing of input and replay
    ppef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, classifier and output register
    ppef_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== dv/printer_passthrough_escape_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// printer_passthrough_escape_filter_tb
// self-checking bench for the printer controller mode byte filter
// ----------------------------------------------------------------------------
// Host bytes go in on the slave stream. Each accepted byte runs through a
// software copy of the filter, which queues the printer items it should give.
// Every item taken from the master stream is checked against the oldest
// queued item. The stimulus has a short directed part and then random
// escape sequences, both well formed and broken, mixed with plain bytes.
// Both sides idle at random, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module printer_passthrough_escape_filter_tb;

    import ppef_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 2 * SEQ_DEPTH + 8;

    // letter bounds for the terminator test
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_M    = 8'h6D;

    // one printer item as it leaves the block
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       leave_mode;
        logic       truncated;
        logic       last;
    } printer_item_t;

    // ------------------------------------------------------------------------
    // filter state copy and queue of printer items still to come
    // ------------------------------------------------------------------------
    class escape_scoreboard;
        bit            in_seq;
        logic [7:0]    seq_buf[SEQ_DEPTH];
        int unsigned   seq_len;
        bit            lost_bytes;
        printer_item_t printer_q[$];
        int            errors;

        function new();
            in_seq     = 1'b0;
            seq_len    = 0;
            lost_bytes = 1'b0;
            errors     = 0;
            foreach (seq_buf[i])
                seq_buf[i] = 8'h00;
        endfunction

        function int pending();
            return printer_q.size();
        endfunction

        function void push_item(logic [7:0] b, bit has, bit leave, bit trunc, bit fin);
            printer_item_t it;
            it.out_byte   = b;
            it.has_byte   = has;
            it.leave_mode = leave;
            it.truncated  = trunc;
            it.last       = fin;
            printer_q.push_back(it);
        endfunction

        // the '#' and ESC tests look at the last byte kept in the store
        function bit ends_sequence(logic [7:0] b);
            logic [7:0] prev;
            prev = (seq_len >= 1) ? seq_buf[seq_len - 1] : 8'h00;
            if ((b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z))
                return 1'b1;
            if (b == CH_AT || b == CH_LT || b == CH_EQ || b == CH_GT || b == CH_TILDE)
                return 1'b1;
            if (prev == CH_HASH)
                return 1'b1;
            if (prev == CH_ESC && (b == CH_7 || b == CH_8))
                return 1'b1;
            return 1'b0;
        endfunction

        function void note_input(logic [7:0] b);
            // outside a sequence: drop NUL and flow control, open on ESC or CSI, else pass
            if (!in_seq)
            begin
                if (b == CH_NUL || b == CH_XON || b == CH_XOFF)
                    return;
                if (b == CH_ESC || b == CH_CSI)
                begin
                    in_seq     = 1'b1;
                    lost_bytes = 1'b0;
                    seq_buf[0] = CH_ESC;
                    seq_len    = 1;
                    if (b == CH_CSI)
                    begin
                        seq_buf[1] = CH_LBRACK;
                        seq_len    = 2;
                    end
                    return;
                end
                push_item(b, 1'b1, 1'b0, 1'b0, 1'b1);
                return;
            end

            // buffer body bytes, the last slot stays free for the terminator
            if (!ends_sequence(b))
            begin
                if (seq_len < SEQ_DEPTH - 1)
                begin
                    seq_buf[seq_len] = b;
                    seq_len++;
                end
                else
                    lost_bytes = 1'b1;
                return;
            end

            if (seq_len > SEQ_DEPTH - 1)
                seq_len = SEQ_DEPTH - 1;
            seq_buf[seq_len] = b;
            seq_len++;
            in_seq = 1'b0;

            // printer off gives a mode-exit item, printer on is swallowed
            if (seq_len == 4 && seq_buf[1] == CH_LBRACK &&
                (seq_buf[2] == CH_4 || seq_buf[2] == CH_5) && seq_buf[3] == CH_I)
            begin
                if (seq_buf[2] == CH_4)
                    push_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
                return;
            end

            // replay the whole stored sequence
            for (int i = 0; i < seq_len; i++)
                push_item(seq_buf[i], 1'b1, 1'b0, lost_bytes, i == seq_len - 1);
        endfunction

        function void check_result(logic [7:0] data, logic [2:0] user, logic fin);
            printer_item_t exp_item;
            if (printer_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual data %02h user %b last %b",
                         $time, data, user, fin);
                errors++;
                return;
            end
            exp_item = printer_q.pop_front();
            if (data !== exp_item.out_byte)
            begin
                $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                         $time, exp_item.out_byte, data);
                errors++;
            end
            if (user[0] !== exp_item.has_byte)
            begin
                $display("%0t: has_byte mismatch, expected %b, actual %b",
                         $time, exp_item.has_byte, user[0]);
                errors++;
            end
            if (user[1] !== exp_item.leave_mode)
            begin
                $display("%0t: leave_mode mismatch, expected %b, actual %b",
                         $time, exp_item.leave_mode, user[1]);
                errors++;
            end
            if (user[2] !== exp_item.truncated)
            begin
                $display("%0t: truncated mismatch, expected %b, actual %b",
                         $time, exp_item.truncated, user[2]);
                errors++;
            end
            if (fin !== exp_item.last)
            begin
                $display("%0t: last mismatch, expected %b, actual %b",
                         $time, exp_item.last, fin);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // in_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // out_byte
    logic [2:0] m_tuser;   // has_byte, leave_mode, truncated
    logic       m_tlast;   // last

    escape_scoreboard sb;
    bit               no_idle;
    bit               hold_request;
    int               hold_left;
    int               rx_wait;
    int               rx_roll;
    int               cycles;
    int               items_sent;
    logic [7:0]       sym_term[5] = '{CH_AT, CH_LT, CH_EQ, CH_GT, CH_TILDE};

    printer_passthrough_escape_filter DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // note accepted input first, then check the output item of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // output side: long hold-off on request, else random stalls
    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        rx_wait   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                rx_roll = $urandom_range(0, 99);
                if (no_idle || rx_roll < 70)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    rx_wait = (rx_roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] body_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'($urandom_range(CH_0, CH_9));
        if (r < 70)
            return CH_SEMI;
        if (r < 85)
            return 8'($urandom);
        return 8'($urandom_range(8'h20, 8'h2F));
    endfunction

    function automatic logic [7:0] letter_byte();
        if ($urandom_range(0, 1))
            return 8'($urandom_range(CH_UP_A, CH_UP_Z));
        return 8'($urandom_range(CH_LO_A, CH_LO_Z));
    endfunction

    // well formed sequence with random body and terminator
    task automatic send_sequence(input int body_len);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            send_item(CH_CSI);
        else
        begin
            send_item(CH_ESC);
            if (r < 9)
                send_item(CH_LBRACK);
        end
        for (int k = 0; k < body_len; k++)
            send_item(body_byte());
        r = $urandom_range(0, 99);
        if (r < 60)
            send_item(letter_byte());
        else if (r < 82)
            send_item(sym_term[$urandom_range(0, 4)]);
        else
        begin
            send_item(CH_HASH);
            send_item(8'($urandom));
        end
    endtask

    // printer on/off command, either opener
    task automatic send_print_cmd();
        if ($urandom_range(0, 1))
            send_item(CH_CSI);
        else
        begin
            send_item(CH_ESC);
            send_item(CH_LBRACK);
        end
        send_item($urandom_range(0, 1) ? CH_4 : CH_5);
        send_item(CH_I);
    endtask

    task automatic send_random_mix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            send_item(8'($urandom));
        else if (r < 38)
            send_print_cmd();
        else if (r < 43)
        begin
            send_item(CH_ESC);
            send_item($urandom_range(0, 1) ? CH_7 : CH_8);
        end
        else if (r < 90)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sequence($urandom_range(12, 20));
            else
                send_sequence($urandom_range(0, 6));
        end
        else
        begin
            // broken: opener and noise
            send_item($urandom_range(0, 1) ? CH_ESC : CH_CSI);
            repeat ($urandom_range(1, 5))
                send_item(8'($urandom));
        end
    endtask

    // main stimulus
    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // plain bytes at the extremes, flow control dropped
        send_item(CH_UP_A);
        send_item(8'hFF);
        send_item(CH_NUL);
        send_item(CH_XON);
        send_item(CH_XOFF);
        // printer off gives a mode-exit item, printer on gives nothing
        send_item(CH_ESC);
        send_item(CH_LBRACK);
        send_item(CH_4);
        send_item(CH_I);
        send_item(CH_CSI);
        send_item(CH_5);
        send_item(CH_I);
        // 7 right after ESC, any byte after '#'
        send_item(CH_ESC);
        send_item(CH_7);
        send_item(CH_ESC);
        send_item(CH_HASH);
        send_item(CH_NUL);
        // control and high bytes stored inside, then overflow past the store;
        // the dropped '#' does not make '0' a terminator
        send_item(CH_ESC);
        send_item(CH_LBRACK);
        send_item(CH_CSI);
        send_item(CH_ESC);
        send_item(8'h80);
        send_item(CH_XON);
        send_item(CH_NUL);
        send_item(CH_XOFF);
        repeat (7) send_item(CH_1);
        send_item(CH_HASH);
        send_item(CH_0);
        send_item(CH_M);
        wait_drained();

        // long output hold-off while input keeps coming
        no_idle      = 1'b1;
        hold_request = 1'b1;
        repeat (20) send_item(8'($urandom_range(8'h20, 8'h7E)));
        send_sequence(10);
        send_sequence(3);
        wait_drained();

        // random traffic, first without idling
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            no_idle = (items_sent < RANDOM_ITEMS / 4);
            send_random_mix();
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ppef_pkg.sv
rtl/ppef_ctrl.sv
rtl/ppef_dp.sv
rtl/printer_passthrough_escape_filter.sv
dv/printer_passthrough_escape_filter_tb.sv
